// File: rtl/vector_angle_approximator_top_macros.svh
// assertion macros for the vector angle approximator
// used by vector_angle_approximator_top; expects clock and reset in scope
`ifndef VECTOR_ANGLE_APPROXIMATOR_TOP_MACROS_SVH
`define VECTOR_ANGLE_APPROXIMATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define VAA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define VAA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define VAA_ASSERT_NOW(label, ante, cons, msg)
`define VAA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/vaa_pkg.sv
// shared types and constants of the vector angle approximator
// no dependencies
package vaa_pkg;

   localparam int ANGLE_BITS = 20;
   localparam int DIV_STEPS  = 2;
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   typedef struct packed {
      logic dx_zero;
      logic dx_neg;
      logic dy_zero;
      logic dy_neg;
      logic sat;
   } flags_type;

endpackage

// File: rtl/vector_angle_approximator_top.sv
// top level of the vector angle approximator: front stages, divider pipeline, back stages
// depends on vaa_pkg, vaa_prep, vaa_div, vaa_post and the assertion macro header
//
//   channel  direction  fields                                   transfer on
//   req      in         point_x center_x point_y center_y Q16.4  req_valid & req_ready
//   rsp      out        angle Q3.FRAC_BITS                       rsp_valid & rsp_ready
//
// one item per cycle while the result is not held at the output;
// the divider stages each retire two quotient bits
// every stage has its own valid bit, so bubbles fill while the output is held
// a held result stalls only the full stages behind it
// synchronous active-high reset clears the valid bits only
`include "vector_angle_approximator_top_macros.svh"

module vector_angle_approximator_top #(
   parameter int FRAC_BITS  = 16,
   parameter int COORD_BITS = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_BITS-1:0]          req_point_x,
   input  logic signed [COORD_BITS-1:0]          req_center_x,
   input  logic signed [COORD_BITS-1:0]          req_point_y,
   input  logic signed [COORD_BITS-1:0]          req_center_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [vaa_pkg::ANGLE_BITS-1:0] rsp_angle
);

   logic                   prep_valid, prep_ready;
   logic [COORD_BITS-1:0]  prep_adx, prep_ady;
   vaa_pkg::flags_type     prep_flags;
   logic                   div_valid, div_ready;
   logic [FRAC_BITS+1:0]   div_t, div_u;
   vaa_pkg::flags_type     div_flags;
   logic [vaa_pkg::ANGLE_BITS-1:0] angle;

   vaa_prep #(
      .COORD_BITS(COORD_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .point_x   (req_point_x),
      .center_x  (req_center_x),
      .point_y   (req_point_y),
      .center_y  (req_center_y),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_adx   (prep_adx),
      .out_ady   (prep_ady),
      .out_flags (prep_flags)
   );

   vaa_div #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_adx    (prep_adx),
      .in_ady    (prep_ady),
      .in_flags  (prep_flags),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_t     (div_t),
      .out_u     (div_u),
      .out_flags (div_flags)
   );

   vaa_post #(
      .FRAC_BITS(FRAC_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_t      (div_t),
      .in_u      (div_u),
      .in_flags  (div_flags),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_angle (angle)
   );

   assign rsp_angle = $signed(angle);

   // input back-pressure only when every stage is full behind a held result
   `VAA_ASSERT_NOW(a_stall_chain, !req_ready, rsp_valid && !rsp_ready, "input stalled with free stage")
   `VAA_ASSERT_NEXT(a_stall_hold, !req_ready, rsp_valid, "result lost during stall")

endmodule

// File: rtl/vaa_prep.sv
// front stages: coordinate differences, magnitudes, sign flags, slope saturation
// depends on vaa_pkg
module vaa_prep #(
   parameter int COORD_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic signed [COORD_BITS-1:0] center_y,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [COORD_BITS-1:0]        out_adx,
   output logic [COORD_BITS-1:0]        out_ady,
   output vaa_pkg::flags_type           out_flags
);

   localparam int CB = COORD_BITS;

   logic            v1_ff, v2_ff;
   logic            rdy1, rdy2;
   logic [CB:0]     dx_in, dy_in, dx_ff, dy_ff;
   logic [CB:0]     ndx, ndy;
   logic [CB-1:0]   adx_in, ady_in, adx_ff, ady_ff;
   logic [CB+1:0]   adx4, ady_ext;
   vaa_pkg::flags_type fl_in, fl_ff;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // stage 1: exact differences
   assign dx_in = {center_x[CB-1], center_x} - {point_x[CB-1], point_x};
   assign dy_in = {center_y[CB-1], center_y} - {point_y[CB-1], point_y};

   // stage 2: magnitudes and flags
   always_comb begin
      ndx     = -dx_ff;
      ndy     = -dy_ff;
      adx_in  = dx_ff[CB] ? ndx[CB-1:0] : dx_ff[CB-1:0];
      ady_in  = dy_ff[CB] ? ndy[CB-1:0] : dy_ff[CB-1:0];
      adx4    = {adx_in, 2'b00};
      ady_ext = {2'b00, ady_in};
      fl_in.dx_zero = (dx_ff == '0);
      fl_in.dx_neg  = dx_ff[CB];
      fl_in.dy_zero = (dy_ff == '0);
      fl_in.dy_neg  = dy_ff[CB];
      fl_in.sat     = (ady_ext >= adx4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (rdy2) begin
         adx_ff <= adx_in;
         ady_ff <= ady_in;
         fl_ff  <= fl_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_adx   = adx_ff;
   assign out_ady   = ady_ff;
   assign out_flags = fl_ff;

endmodule

// File: rtl/vaa_div.sv
// pipelined restoring dividers for slope and inverse slope, two quotient bits per stage
// depends on vaa_pkg
module vaa_div #(
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [COORD_BITS-1:0]   in_adx,
   input  logic [COORD_BITS-1:0]   in_ady,
   input  vaa_pkg::flags_type      in_flags,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [FRAC_BITS+1:0]    out_t,
   output logic [FRAC_BITS+1:0]    out_u,
   output vaa_pkg::flags_type      out_flags
);

   localparam int MW  = COORD_BITS;
   localparam int QB  = FRAC_BITS + 2;
   localparam int RQW = MW + QB;
   localparam int NST = (QB + vaa_pkg::DIV_STEPS - 1) / vaa_pkg::DIV_STEPS;

   logic [NST-1:0]     v_ff;
   logic [NST:0]       rdy;
   logic [RQW-1:0]     rqt_ff [NST];
   logic [RQW-1:0]     rqu_ff [NST];
   logic [MW-1:0]      adx_ff [NST-1];
   logic [MW-1:0]      ady_ff [NST-1];
   vaa_pkg::flags_type fl_ff  [NST];

   // one restoring step on {remainder, quotient}
   function automatic logic [RQW-1:0] div_step(input logic [RQW-1:0] rq,
                                               input logic [MW-1:0]  d);
      logic [MW:0]    sh;
      logic [MW+1:0]  diff;
      logic [RQW-1:0] res;
      sh   = rq[RQW-1:QB-1];
      diff = {1'b0, sh} - {2'b00, d};
      if (diff[MW+1]) begin
         res = {sh[MW-1:0], rq[QB-2:0], 1'b0};
      end else begin
         res = {diff[MW-1:0], rq[QB-2:0], 1'b1};
      end
      return res;
   endfunction

   assign rdy[NST] = out_ready;
   assign in_ready = rdy[0];

   for (genvar s = 0; s < NST; s++) begin : g_stage
      logic               v_src;
      logic [RQW-1:0]     rqt_src, rqu_src, rqt_in, rqu_in;
      logic [MW-1:0]      adx_src, ady_src;
      vaa_pkg::flags_type fl_src;

      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign adx_src = in_adx;
         assign ady_src = in_ady;
         assign fl_src  = in_flags;
         assign rqt_src = {2'b00, in_ady, {FRAC_BITS{1'b0}}};
         assign rqu_src = {2'b00, in_adx, {FRAC_BITS{1'b0}}};
      end else begin : g_next
         assign v_src   = v_ff[s-1];
         assign adx_src = adx_ff[s-1];
         assign ady_src = ady_ff[s-1];
         assign fl_src  = fl_ff[s-1];
         assign rqt_src = rqt_ff[s-1];
         assign rqu_src = rqu_ff[s-1];
      end

      assign rdy[s] = !v_ff[s] || rdy[s+1];

      always_comb begin
         rqt_in = rqt_src;
         rqu_in = rqu_src;
         for (int k = 0; k < vaa_pkg::DIV_STEPS; k++) begin
            if (s * vaa_pkg::DIV_STEPS + k < QB) begin
               rqt_in = div_step(rqt_in, adx_src);
               rqu_in = div_step(rqu_in, ady_src);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            rqt_ff[s] <= rqt_in;
            rqu_ff[s] <= rqu_in;
            fl_ff[s]  <= fl_src;
         end
      end

      if (s < NST - 1) begin : g_div
         always_ff @(posedge clock) begin
            if (rdy[s]) begin
               adx_ff[s] <= adx_src;
               ady_ff[s] <= ady_src;
            end
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_t     = rqt_ff[NST-1][QB-1:0];
   assign out_u     = rqu_ff[NST-1][QB-1:0];
   assign out_flags = fl_ff[NST-1];

endmodule

// File: rtl/vaa_post.sv
// back stages: both arctangent approximations, quadrant fixup, output register
// depends on vaa_pkg
module vaa_post #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [FRAC_BITS+1:0]           in_t,
   input  logic [FRAC_BITS+1:0]           in_u,
   input  vaa_pkg::flags_type             in_flags,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [vaa_pkg::ANGLE_BITS-1:0] out_angle
);

   localparam int F    = FRAC_BITS;
   localparam int QB   = F + 2;
   localparam int CW   = F + 3;
   localparam int PW   = F + 3;
   localparam int KW   = PW - 2;
   localparam int S2   = F + 1;
   localparam int UKW  = F + S2;
   localparam int PRW  = QB + CW;
   localparam int PKW  = PW + KW;
   localparam int MGW  = 2 * F + 2;
   localparam int XW   = PW + 7;
   localparam int R5W  = F + 3;
   localparam int MAGW = F + 1;
   localparam int AB   = vaa_pkg::ANGLE_BITS;
   localparam int RW   = (F + 4 > AB) ? F + 4 : AB;

   localparam logic [63:0] KNEE64  = (64'd197692 << F) / 64'd100000;
   localparam logic [63:0] C434_64 = (64'd434 << F) / 64'd100;
   localparam logic [63:0] K64     = (64'd100 << PW) / 64'd427;
   localparam logic [63:0] K2_64   = (64'd3 << S2) / 64'd5;
   localparam logic [63:0] HP64    = vaa_pkg::PI_Q60 >> (61 - F);
   localparam logic [63:0] PI64    = vaa_pkg::PI_Q60 >> (60 - F);
   localparam logic [65:0] THR66   = ({2'b00, vaa_pkg::PI_Q60} * 66'd3) >> (61 - F);

   localparam logic [QB-1:0]  T_SAT = {QB{1'b1}};
   localparam logic [QB-1:0]  KNEE  = KNEE64[QB-1:0];
   localparam logic [CW-1:0]  C434  = C434_64[CW-1:0];
   localparam logic [KW-1:0]  KC    = K64[KW-1:0];
   localparam logic [S2-1:0]  K2C   = K2_64[S2-1:0];
   localparam logic [F:0]     HP    = HP64[F:0];
   localparam logic [RW-1:0]  HP_R  = HP64[RW-1:0];
   localparam logic [RW-1:0]  PI_R  = PI64[RW-1:0];
   localparam logic [RW-1:0]  THR_R = THR66[RW-1:0];

   logic [4:0] v_ff;
   logic [5:0] rdy;

   logic [QB-1:0]  t_eff, t1_ff;
   logic [CW-1:0]  d1_in, d1_ff;
   logic           low1_in, low1_ff, low2_ff, low3_ff;
   logic [F-1:0]   u1_ff;
   logic [UKW-1:0] uk1_in, uk1_ff;
   logic [PRW-1:0] prod2_in, prod2_ff;
   logic [F-1:0]   q5;
   logic [R5W-1:0] r5;
   logic [F-1:0]   v5;
   logic [F:0]     m2_in, m2_ff;
   logic [PW-1:0]  p3_in, p3_ff;
   logic [PKW-1:0] pk3_in, pk3_ff;
   logic [MGW-1:0] mg3_in, mg3_ff;
   logic [KW-1:0]  q0;
   logic [XW-1:0]  r4;
   logic [MAGW-1:0] maglo, maghi, mag4_in, mag4_ff;
   logic [RW-1:0]  mext, sm, res;
   logic           neg;
   logic [AB-1:0]  angle_ff;
   vaa_pkg::flags_type fl1_ff, fl2_ff, fl3_ff, fl4_ff;

   assign rdy[5]   = out_ready;
   assign in_ready = rdy[0];
   for (genvar i = 0; i < 5; i++) begin : g_rdy
      assign rdy[i] = !v_ff[i] || rdy[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
         if (rdy[4]) v_ff[4] <= v_ff[3];
      end
   end

   // stage 1: saturate slope, knee test, inverse slope times 3/5 reciprocal
   always_comb begin
      t_eff   = in_flags.sat ? T_SAT : in_t;
      low1_in = (t_eff < KNEE);
      d1_in   = C434 - CW'(t_eff);
      uk1_in  = UKW'(in_u[F-1:0]) * UKW'(K2C);
   end

   // stage 2: polynomial product, 3u/5 correction, 1 - 0.6u
   always_comb begin
      prod2_in = PRW'(t1_ff) * PRW'(d1_ff);
      q5       = uk1_ff[UKW-1:S2];
      r5       = (R5W'(u1_ff) * R5W'(3)) - (R5W'(q5) * R5W'(5));
      v5       = q5 + F'(r5 >= R5W'(5));
      m2_in    = {1'b1, {F{1'b0}}} - {1'b0, v5};
   end

   // stage 3: scale by 100/427 reciprocal, scale by pi/2
   always_comb begin
      p3_in  = prod2_ff[F+PW-1:F];
      pk3_in = PKW'(p3_in) * PKW'(KC);
      mg3_in = MGW'(m2_ff) * MGW'(HP);
   end

   // stage 4: quotient correction and branch select
   always_comb begin
      q0      = pk3_ff[PKW-1:PW];
      r4      = (XW'(p3_ff) * XW'(100)) - (XW'(q0) * XW'(427));
      maglo   = q0 + KW'(r4 >= XW'(427));
      maghi   = mg3_ff[2*F:F];
      mag4_in = low3_ff ? maglo : maghi;
   end

   // stage 5: sign and quadrant
   always_comb begin
      neg  = !fl4_ff.dy_zero && (fl4_ff.dx_neg != fl4_ff.dy_neg);
      mext = RW'(mag4_ff);
      sm   = neg ? (RW'(0) - mext) : mext;
      if (fl4_ff.dx_zero) begin
         res = (!fl4_ff.dy_zero && !fl4_ff.dy_neg) ? HP_R : THR_R;
      end else begin
         res = fl4_ff.dx_neg ? (sm + PI_R) : sm;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         t1_ff   <= t_eff;
         d1_ff   <= d1_in;
         low1_ff <= low1_in;
         u1_ff   <= in_u[F-1:0];
         uk1_ff  <= uk1_in;
         fl1_ff  <= in_flags;
      end
      if (rdy[1]) begin
         prod2_ff <= prod2_in;
         m2_ff    <= m2_in;
         low2_ff  <= low1_ff;
         fl2_ff   <= fl1_ff;
      end
      if (rdy[2]) begin
         p3_ff   <= p3_in;
         pk3_ff  <= pk3_in;
         mg3_ff  <= mg3_in;
         low3_ff <= low2_ff;
         fl3_ff  <= fl2_ff;
      end
      if (rdy[3]) begin
         mag4_ff <= mag4_in;
         fl4_ff  <= fl3_ff;
      end
      if (rdy[4]) begin
         angle_ff <= res[AB-1:0];
      end
   end

   assign out_valid = v_ff[4];
   assign out_angle = angle_ff;

endmodule
